/* hdl/tpsg_pkg.sv */
// Shared types and codes for the timed profile setpoint generator.
`default_nettype none
package tpsg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION    = 2'd0,
    CFG_FULL_SCALE  = 2'd1,
    CFG_POINT_COUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_SEEK   = 3'd5,
    ACT_SLIP   = 3'd6,
    ACT_LOAD   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_RUNNING  = 3'd1,
    ST_PAUSED   = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] amount_ms;
    logic [3:0]  point_index;
    logic [9:0]  point_time;
    logic [9:0]  point_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] setpoint;
    logic [31:0] elapsed_ms;
    logic [31:0] remaining_ms;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_APPLY, OP_EVAL, OP_IDX_LAST, OP_IDX_ONE, OP_IDX_INC,
    OP_IDX_DEC, OP_PT_MUL, OP_DIV_S, OP_DIV_SPAN, OP_SET_T0, OP_SET_T1, OP_LVL_Y,
    OP_LVL_Y0, OP_FRAC_MUL, OP_FRAC_ZERO, OP_SET_FRAC, OP_LERP_MUL, OP_SET_LVL,
    OP_SC_MUL, OP_SC_X10, OP_SET_SP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic need_sp;
    logic ge;
    logic at_end;
    logic div_busy;
    logic seg_empty;
    logic e_before;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/tpsg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpsg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/tpsg_div.sv */
// Dividers: restoring serial divider and reciprocal divider by the constant SCALE.
`default_nettype none
module tpsg_div #(
  parameter int DW = 42
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [31:0]   divisor,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [32:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic [32:0]   trial;
  logic          take;

  assign trial = {rem[31:0], quotient[DW-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(DW);
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= take ? (trial - {1'b0, dvs}) : trial;
      quotient <= {quotient[DW-2:0], take};
      cnt      <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// Divide by SCALE, 16 quotient bits per digit: a reciprocal estimate of each
// digit that is at most one low, then one compare and subtract.
module tpsg_cdiv #(
  parameter int DW    = 42,
  parameter int SCALE = 1000
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  localparam int NCH = (DW + 15) / 16;
  localparam int PW  = NCH * 16;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SCALE));

  logic [PW-1:0] num;
  logic [PW-1:0] acc;
  logic [15:0]   rem;
  logic [CW-1:0] cnt;
  logic          phase;
  logic [31:0]   v, v_now, qs, r_try;
  logic [63:0]   est;
  logic [15:0]   qe, q_next, rem_next;
  logic          fix;

  assign v_now    = {rem, num[PW-1 -: 16]};
  assign est      = 64'(v_now) * 64'(RECIP);
  assign qs       = 32'(qe) * 32'(SCALE);
  assign r_try    = v - qs;
  assign fix      = r_try >= 32'(SCALE);
  assign q_next   = fix ? (qe + 16'd1) : qe;
  assign rem_next = fix ? 16'(r_try - 32'(SCALE)) : r_try[15:0];
  assign quotient = acc[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      phase <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CW'(NCH);
      phase <= 1'b0;
      num   <= PW'(dividend);
      rem   <= '0;
    end else if (busy) begin
      if (!phase) begin
        // estimate the next digit from the reciprocal
        v     <= v_now;
        qe    <= est[47:32];
        num   <= num << 16;
        phase <= 1'b1;
      end else begin
        // settle the digit and carry the remainder into the next one
        rem   <= rem_next;
        acc   <= {acc[PW-17:0], q_next};
        cnt   <= cnt - CW'(1);
        phase <= 1'b0;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/tpsg_ctrl.sv */
// Sequencer for item handling, segment search and interpolation steps.
`default_nettype none
module tpsg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tpsg_pkg::sts_t sts,
  output tpsg_pkg::cmd_t     cmd
);
  import tpsg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_APPLY, S_EVAL, S_CHK, S_L_RD, S_L_MUL, S_L_CMP, S_S_CHK, S_S_MUL,
    S_S_CMP, S_T0_RD, S_T0_MUL, S_T0_DIV, S_T0_WAIT, S_T1_RD, S_T1_MUL, S_T1_DIV,
    S_T1_WAIT, S_FRAC, S_FRAC_DIV, S_FRAC_WAIT, S_LERP_MUL, S_LERP_DIV,
    S_LERP_WAIT, S_SC_MUL, S_SC_X10, S_SC_DIV, S_SC_WAIT, S_OUT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_CAPTURE; state_next = S_APPLY;
        end
      end
      S_APPLY: begin cmd.op = OP_APPLY; state_next = S_EVAL; end
      S_EVAL:  begin cmd.op = OP_EVAL;  state_next = S_CHK; end
      S_CHK: begin
        if (sts.need_sp) begin
          cmd.op = OP_IDX_LAST; state_next = S_L_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_L_RD:  state_next = S_L_MUL;
      S_L_MUL: begin cmd.op = OP_PT_MUL; state_next = S_L_CMP; end
      S_L_CMP: begin
        if (sts.ge) begin
          cmd.op = OP_LVL_Y; state_next = S_SC_MUL;
        end else begin
          cmd.op = OP_IDX_ONE; state_next = S_S_CHK;
        end
      end
      S_S_CHK: begin
        if (sts.at_end) begin
          cmd.op = OP_IDX_DEC; state_next = S_T0_RD;
        end else begin
          state_next = S_S_MUL;
        end
      end
      S_S_MUL: begin cmd.op = OP_PT_MUL; state_next = S_S_CMP; end
      S_S_CMP: begin
        if (sts.ge) begin
          cmd.op = OP_IDX_INC; state_next = S_S_CHK;
        end else begin
          cmd.op = OP_IDX_DEC; state_next = S_T0_RD;
        end
      end
      S_T0_RD:  state_next = S_T0_MUL;
      S_T0_MUL: begin cmd.op = OP_PT_MUL; state_next = S_T0_DIV; end
      S_T0_DIV: begin cmd.op = OP_DIV_S;  state_next = S_T0_WAIT; end
      S_T0_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op = OP_SET_T0; state_next = S_T1_RD;
        end
      end
      S_T1_RD:  state_next = S_T1_MUL;
      S_T1_MUL: begin cmd.op = OP_PT_MUL; state_next = S_T1_DIV; end
      S_T1_DIV: begin cmd.op = OP_DIV_S;  state_next = S_T1_WAIT; end
      S_T1_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op = OP_SET_T1; state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        if (sts.seg_empty) begin
          cmd.op = OP_LVL_Y0; state_next = S_SC_MUL;
        end else if (sts.e_before) begin
          cmd.op = OP_FRAC_ZERO; state_next = S_LERP_MUL;
        end else begin
          cmd.op = OP_FRAC_MUL; state_next = S_FRAC_DIV;
        end
      end
      S_FRAC_DIV: begin cmd.op = OP_DIV_SPAN; state_next = S_FRAC_WAIT; end
      S_FRAC_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op = OP_SET_FRAC; state_next = S_LERP_MUL;
        end
      end
      S_LERP_MUL: begin cmd.op = OP_LERP_MUL; state_next = S_LERP_DIV; end
      S_LERP_DIV: begin cmd.op = OP_DIV_S;    state_next = S_LERP_WAIT; end
      S_LERP_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op = OP_SET_LVL; state_next = S_SC_MUL;
        end
      end
      S_SC_MUL: begin cmd.op = OP_SC_MUL; state_next = S_SC_X10; end
      S_SC_X10: begin cmd.op = OP_SC_X10; state_next = S_SC_DIV; end
      S_SC_DIV: begin cmd.op = OP_DIV_S;  state_next = S_SC_WAIT; end
      S_SC_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op = OP_SET_SP; state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op = OP_OUT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/tpsg_dp.sv */
// Datapath: timing state, point table, search compare, dividers and result register.
`default_nettype none
module tpsg_dp #(
  parameter int MAX_POINTS = 16,
  parameter int SCALE      = 1000
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire tpsg_pkg::in_item_t           in_data,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output tpsg_pkg::out_item_t               out_data,
  input  wire tpsg_pkg::cmd_t               cmd,
  output tpsg_pkg::sts_t                    sts
);
  import tpsg_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = IW + 1;
  localparam int SW = $clog2(SCALE + 1);
  localparam int DW = 32 + SW;

  // configuration
  logic [31:0] duration;
  logic [15:0] full_scale;
  logic [4:0]  point_count;

  // timing state
  logic [31:0] clock_now, start_time, held_elapsed;
  logic        running_flag, paused_flag, stopped_flag;

  in_item_t    item;

  // per-item work registers
  logic [2:0]    st;
  logic [31:0]   el, rem;
  logic [DW-1:0] es1, prod;
  logic [IW-1:0] idx;
  logic [9:0]    ylat, y0, y1, lvl;
  logic [31:0]   t0, t1;
  logic [SW-1:0] frac;
  logic          neg;
  logic [14:0]   sp;

  logic [NW-1:0] n_eff;
  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
  end

  // table
  logic [19:0]   rdata;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  assign ram_we    = (cmd.op == OP_APPLY) && (action_t'(item.action) == ACT_LOAD) &&
                     (32'(item.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = IW'(item.point_index);

  tpsg_ram #(.WIDTH(20), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item.point_time, item.point_level}),
    .raddr (idx),
    .rdata (rdata)
  );

  // dividers: serial one for the segment span, reciprocal one for SCALE
  logic          div_busy, sdiv_busy, cdiv_busy;
  logic [DW-1:0] quo, squo, cquo;
  logic [31:0]   span;
  assign span     = t1 - t0;
  assign div_busy = sdiv_busy || cdiv_busy;
  // only the fraction step takes the span quotient
  assign quo      = (cmd.op == OP_SET_FRAC) ? squo : cquo;

  tpsg_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_SPAN),
    .dividend (prod),
    .divisor  (span),
    .busy     (sdiv_busy),
    .quotient (squo)
  );

  tpsg_cdiv #(.DW(DW), .SCALE(SCALE)) u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_S),
    .dividend (prod),
    .busy     (cdiv_busy),
    .quotient (cquo)
  );

  // status and elapsed from the state after the action
  logic [31:0] run_el, st_el, el_now, rem_now;
  status_t     st_now;
  always_comb begin
    run_el = clock_now - start_time;
    if (paused_flag) begin
      st_el = held_elapsed;
    end else if (running_flag) begin
      st_el = run_el;
    end else if (start_time != '0) begin
      st_el = run_el;
    end else begin
      st_el = held_elapsed;
    end
    if (stopped_flag) begin
      st_now = ST_STOPPED;
    end else if (duration == '0) begin
      st_now = ST_IDLE;
    end else if (start_time == '0 && held_elapsed == '0 && !running_flag) begin
      st_now = ST_IDLE;
    end else if (st_el >= duration) begin
      st_now = ST_FINISHED;
    end else if (paused_flag) begin
      st_now = ST_PAUSED;
    end else if (running_flag) begin
      st_now = ST_RUNNING;
    end else begin
      st_now = ST_IDLE;
    end
    if (paused_flag) begin
      el_now = held_elapsed;
    end else if (!running_flag) begin
      el_now = '0;
    end else begin
      el_now = (run_el < duration) ? run_el : duration;
    end
    rem_now = (running_flag && el_now < duration) ? (duration - el_now) : '0;
  end

  // point time clamped to the scale
  logic [SW-1:0] xs;
  assign xs = (32'(rdata[19:10]) > 32'(SCALE)) ? SW'(SCALE) : SW'(rdata[19:10]);

  logic [DW-1:0] pt_prod, es1_next, frac_prod, lerp_prod, sc_prod;
  logic [10:0]   diff;
  logic [9:0]    mag;
  assign pt_prod   = xs * duration;
  assign es1_next  = el_now * SW'(SCALE) + DW'(SCALE);
  assign frac_prod = (el - t0) * SW'(SCALE);
  assign diff      = {1'b0, y1} - {1'b0, y0};
  assign mag       = diff[10] ? 10'(-diff) : diff[9:0];
  assign lerp_prod = mag * frac;
  assign sc_prod   = lvl * full_scale;

  assign sts.need_sp   = (st == 3'(ST_RUNNING)) && (n_eff >= NW'(2));
  assign sts.ge        = prod < es1;
  assign sts.at_end    = {1'b0, idx} == (n_eff - NW'(1));
  assign sts.div_busy  = div_busy;
  assign sts.seg_empty = t1 <= t0;
  assign sts.e_before  = el < t0;
  assign sts.out_free  = !out_valid || !out_stall;

  logic [31:0] target;
  assign target = (item.amount_ms > duration) ? duration : item.amount_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration     <= '0;
      full_scale   <= '0;
      point_count  <= '0;
      clock_now    <= '0;
      start_time   <= '0;
      held_elapsed <= '0;
      running_flag <= 1'b0;
      paused_flag  <= 1'b0;
      stopped_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_DURATION:    duration    <= cfg_data;
          CFG_FULL_SCALE:  full_scale  <= cfg_data[15:0];
          CFG_POINT_COUNT: point_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_APPLY) begin
        unique case (action_t'(item.action))
          ACT_TICK: clock_now <= clock_now + item.amount_ms;
          ACT_START: begin
            if (duration != '0) begin
              start_time   <= clock_now;
              held_elapsed <= '0;
              running_flag <= 1'b1;
            end else begin
              running_flag <= 1'b0;
            end
            paused_flag  <= 1'b0;
            stopped_flag <= 1'b0;
          end
          ACT_STOP: begin
            running_flag <= 1'b0;
            paused_flag  <= 1'b0;
            stopped_flag <= 1'b1;
            held_elapsed <= '0;
            start_time   <= '0;
          end
          ACT_PAUSE: begin
            if (running_flag && !paused_flag) begin
              held_elapsed <= (run_el < duration) ? run_el : duration;
              paused_flag  <= 1'b1;
              stopped_flag <= 1'b0;
            end
          end
          ACT_RESUME: begin
            if (running_flag && paused_flag) begin
              start_time   <= clock_now - held_elapsed;
              paused_flag  <= 1'b0;
              stopped_flag <= 1'b0;
            end
          end
          ACT_SEEK: begin
            if (running_flag) begin
              if (paused_flag) begin
                held_elapsed <= target;
              end else begin
                start_time <= clock_now - target;
              end
            end
          end
          ACT_SLIP: begin
            if (running_flag && !paused_flag) begin
              start_time <= start_time + item.amount_ms;
            end
          end
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // work registers carry no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: item <= in_data;
      OP_EVAL: begin
        st  <= st_now;
        el  <= el_now;
        rem <= rem_now;
        es1 <= es1_next;
        sp  <= '0;
      end
      OP_IDX_LAST: idx <= IW'(n_eff - NW'(1));
      OP_IDX_ONE:  idx <= IW'(1);
      OP_IDX_INC:  idx <= idx + IW'(1);
      OP_IDX_DEC:  idx <= idx - IW'(1);
      OP_PT_MUL: begin
        prod <= pt_prod;
        ylat <= rdata[9:0];
      end
      OP_SET_T0: begin
        t0  <= quo[31:0];
        y0  <= ylat;
        idx <= idx + IW'(1);
      end
      OP_SET_T1: begin
        t1 <= quo[31:0];
        y1 <= ylat;
      end
      OP_LVL_Y:     lvl  <= ylat;
      OP_LVL_Y0:    lvl  <= y0;
      OP_FRAC_MUL:  prod <= frac_prod;
      OP_FRAC_ZERO: frac <= '0;
      OP_SET_FRAC:  frac <= (quo > DW'(SCALE)) ? SW'(SCALE) : quo[SW-1:0];
      OP_LERP_MUL: begin
        prod <= lerp_prod;
        neg  <= diff[10];
      end
      OP_SET_LVL: lvl  <= neg ? (y0 - quo[9:0]) : (y0 + quo[9:0]);
      OP_SC_MUL:  prod <= sc_prod;
      OP_SC_X10:  prod <= (prod << 3) + (prod << 1);
      OP_SET_SP:  sp   <= (quo > DW'(15'h7FFF)) ? 15'h7FFF : quo[14:0];
      OP_OUT: begin
        out_data.status       <= st;
        out_data.setpoint     <= sp;
        out_data.elapsed_ms   <= el;
        out_data.remaining_ms <= rem;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/timed_profile_setpoint_generator_unit.sv */
// Top level of the timed profile setpoint generator.
`default_nettype none
// Keeps a millisecond clock advanced by tick items, plus run, pause and stop
// flags, and returns one result per item: status, elapsed and remaining time,
// and while running with two or more control points a setpoint interpolated
// over the point table and scaled by full_scale*10/SCALE, saturated to 32767.
// Items are handled one at a time. The segment search reads the table one
// point at a time, the up to four divisions by SCALE settle 16 quotient bits
// per digit by reciprocal multiplication, and the division by the segment
// span runs one quotient bit a cycle through the serial divider. The next
// item is taken while a finished result waits on out_stall; the table write
// of a load item happens in the apply step that follows its capture.
// Configuration writes land at once and must only come while the block is
// idle.
module timed_profile_setpoint_generator_unit #(
  parameter int MAX_POINTS = 16,
  parameter int SCALE      = 1000
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire tpsg_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tpsg_pkg::out_item_t                  out_data
);
  import tpsg_pkg::*;

  cmd_t cmd;   // step to run this cycle
  sts_t sts;   // datapath flags that steer the sequence

  // hold the input in stall while an item is in work; transfer starts it
  tpsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // timing state, point table, dividers and result register
  tpsg_dp #(.MAX_POINTS(MAX_POINTS), .SCALE(SCALE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* tb/sv/timed_profile_setpoint_generator_unit_tb.sv */
// Self-checking testbench for the timed profile setpoint generator top level.
`default_nettype none

// Holds a bit-level prediction of the profile generator and the queue of
// results it still owes; transfers on the input side feed it, transfers on
// the output side are checked against it in order.
class profile_scoreboard;
  logic [31:0] duration;
  logic [15:0] full_scale;
  logic [4:0]  point_count;
  logic [31:0] clock_now;
  logic [31:0] start_time;
  logic [31:0] held_elapsed;
  bit          running, paused, stopped;
  logic [9:0]  pt_time [16];
  logic [9:0]  pt_level[16];
  tpsg_pkg::out_item_t owed[$];
  int          errors;
  int          checked;
  int          running_seen;

  function new();
    duration = 0; full_scale = 0; point_count = 0;
    clock_now = 0; start_time = 0; held_elapsed = 0;
    running = 0; paused = 0; stopped = 0;
    errors = 0; checked = 0; running_seen = 0;
    for (int i = 0; i < 16; i++) begin
      pt_time[i] = 0;
      pt_level[i] = 0;
    end
  endfunction

  function void set_reg(tpsg_pkg::cfg_reg_t idx, logic [31:0] v);
    case (idx)
      tpsg_pkg::CFG_DURATION:    duration = v;
      tpsg_pkg::CFG_FULL_SCALE:  full_scale = v[15:0];
      tpsg_pkg::CFG_POINT_COUNT: point_count = v[4:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] point_ms(int i);
    longint unsigned x;
    x = pt_time[i];
    if (x > 1000) x = 1000;
    return (x * longint'(duration)) / 1000;
  endfunction

  function logic [14:0] scaled(longint lvl);
    longint v;
    if (lvl < 0) return 0;
    v = (lvl * longint'(full_scale) * 10) / 1000;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function logic [14:0] level_at(logic [31:0] e);
    int n, seg;
    logic [31:0] t0, t1, span;
    longint unsigned frac;
    longint y0, y1, lvl;
    n = (point_count > 16) ? 16 : int'(point_count);
    if (n < 2) return 0;
    if (e >= point_ms(n - 1)) return scaled(longint'(pt_level[n - 1]));
    seg = 1;
    while (seg < n - 1 && e >= point_ms(seg)) seg++;
    t0 = point_ms(seg - 1);
    t1 = point_ms(seg);
    y0 = pt_level[seg - 1];
    y1 = pt_level[seg];
    // Empty or backward segment: hold its first level.
    if (t1 <= t0) return scaled(y0);
    span = t1 - t0;
    if (e < t0) frac = 0;
    else frac = (longint'(e - t0) * 1000) / longint'(span);
    if (frac > 1000) frac = 1000;
    lvl = y0 + ((y1 - y0) * longint'(frac)) / 1000;
    return scaled(lvl);
  endfunction

  function tpsg_pkg::status_t status_now();
    logic [31:0] el;
    if (stopped) return tpsg_pkg::ST_STOPPED;
    if (duration == 0) return tpsg_pkg::ST_IDLE;
    if (start_time == 0 && held_elapsed == 0 && !running) return tpsg_pkg::ST_IDLE;
    if (paused) el = held_elapsed;
    else if (running) el = clock_now - start_time;
    else el = (start_time != 0) ? clock_now - start_time : held_elapsed;
    if (el >= duration) return tpsg_pkg::ST_FINISHED;
    if (paused) return tpsg_pkg::ST_PAUSED;
    if (running) return tpsg_pkg::ST_RUNNING;
    return tpsg_pkg::ST_IDLE;
  endfunction

  function tpsg_pkg::out_item_t advance(tpsg_pkg::in_item_t it);
    tpsg_pkg::out_item_t r;
    logic [31:0] el, tgt;
    tpsg_pkg::status_t st;
    case (tpsg_pkg::action_t'(it.action))
      tpsg_pkg::ACT_TICK: clock_now += it.amount_ms;
      tpsg_pkg::ACT_START: begin
        if (duration > 0) begin
          start_time = clock_now;
          held_elapsed = 0;
          running = 1;
        end else begin
          running = 0;
        end
        paused = 0;
        stopped = 0;
      end
      tpsg_pkg::ACT_STOP: begin
        running = 0; paused = 0; stopped = 1;
        held_elapsed = 0; start_time = 0;
      end
      tpsg_pkg::ACT_PAUSE: begin
        if (running && !paused) begin
          el = clock_now - start_time;
          held_elapsed = (el < duration) ? el : duration;
          paused = 1;
          stopped = 0;
        end
      end
      tpsg_pkg::ACT_RESUME: begin
        if (running && paused) begin
          start_time = clock_now - held_elapsed;
          paused = 0;
          stopped = 0;
        end
      end
      tpsg_pkg::ACT_SEEK: begin
        tgt = (it.amount_ms > duration) ? duration : it.amount_ms;
        if (running) begin
          if (paused) held_elapsed = tgt;
          else start_time = clock_now - tgt;
        end
      end
      tpsg_pkg::ACT_SLIP: if (running && !paused) start_time += it.amount_ms;
      default: begin
        pt_time[it.point_index] = it.point_time;
        pt_level[it.point_index] = it.point_level;
      end
    endcase
    st = status_now();
    if (paused) el = held_elapsed;
    else if (!running) el = 0;
    else begin
      el = clock_now - start_time;
      if (el > duration) el = duration;
    end
    r.status = st;
    r.elapsed_ms = el;
    r.remaining_ms = (running && el < duration) ? duration - el : 0;
    r.setpoint = (st == tpsg_pkg::ST_RUNNING) ? level_at(el) : 0;
    return r;
  endfunction

  function void note_input(tpsg_pkg::in_item_t it);
    owed.push_back(advance(it));
  endfunction

  function void check_result(tpsg_pkg::out_item_t got);
    tpsg_pkg::out_item_t exp_r;
    checked++;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = owed.pop_front();
    if (exp_r.status == tpsg_pkg::ST_RUNNING) running_seen++;
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp st=%0d sp=%0d el=%0d rem=%0d  got st=%0d sp=%0d el=%0d rem=%0d",
                 exp_r.status, exp_r.setpoint, exp_r.elapsed_ms, exp_r.remaining_ms,
                 got.status, got.setpoint, got.elapsed_ms, got.remaining_ms);
    end
  endfunction
endclass

module timed_profile_setpoint_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpsg_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;

  // Stretches with this set run with no gaps and no stalls.
  bit quiet = 0;
  int phases = 0;
  profile_scoreboard board = new();

  timed_profile_setpoint_generator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 250);
  endfunction

  // Receiver side: hold out_stall for random stretches.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      int g;
      g = pick_gap();
      out_stall <= (g > 0);
      stall_left <= (g > 0) ? g - 1 : $urandom_range(0, 4);
    end
  end

  // Check every output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  // Drive one item, optionally after a gap; return at the edge of its transfer.
  task automatic send(in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
  endtask

  // Stop sending and wait until every owed result has been transferred.
  task automatic drain();
    in_valid <= 0;
    while (board.owed.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic set_config(logic [31:0] dur, logic [15:0] fs, logic [4:0] cnt);
    cfg_we <= 1; cfg_index <= CFG_DURATION; cfg_data <= dur;
    @(posedge clk);
    cfg_index <= CFG_FULL_SCALE; cfg_data <= {16'd0, fs};
    @(posedge clk);
    cfg_index <= CFG_POINT_COUNT; cfg_data <= {27'd0, cnt};
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(CFG_DURATION, dur);
    board.set_reg(CFG_FULL_SCALE, {16'd0, fs});
    board.set_reg(CFG_POINT_COUNT, {27'd0, cnt});
  endtask

  function automatic in_item_t make_item(action_t a, logic [31:0] amt);
    in_item_t it;
    it = '0;
    it.action = a;
    it.amount_ms = amt;
    it.point_index = $urandom_range(0, 15);
    it.point_time = $urandom_range(0, 1023);
    it.point_level = $urandom_range(0, 1023);
    return it;
  endfunction

  // Random item, weighted toward ordinary run/pause/seek sequences.
  function automatic in_item_t random_item(logic [31:0] dur);
    in_item_t it;
    int r, k;
    action_t a;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 38) a = ACT_TICK;
    else if (r < 46) a = ACT_START;
    else if (r < 50) a = ACT_STOP;
    else if (r < 58) a = ACT_PAUSE;
    else if (r < 66) a = ACT_RESUME;
    else if (r < 76) a = ACT_SEEK;
    else if (r < 83) a = ACT_SLIP;
    else a = ACT_LOAD;
    it = make_item(a, $urandom());
    case (a)
      ACT_TICK:
        if (k < 70) it.amount_ms = $urandom_range(0, 300);
        else if (k < 92) it.amount_ms = $urandom_range(0, 5000);
      ACT_SEEK:
        if (k < 65) it.amount_ms = 32'(({32'd0, $urandom()} % ({32'd0, dur} + 1)));
      ACT_SLIP:
        if (k < 45) it.amount_ms = $urandom_range(0, 400);
        else if (k < 85) it.amount_ms = -$urandom_range(0, 400);
      ACT_LOAD:
        // Keep most tables ordered so segments are meaningful.
        if (k < 65) it.point_time = it.point_index * 62 + $urandom_range(0, 61);
      default: ;
    endcase
    return it;
  endfunction

  initial begin : main
    logic [31:0] dur;
    logic [15:0] fs;
    logic [4:0]  cnt;
    in_item_t    it;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: fill the whole table, then walk every command and edge case.
    set_config(32'd1000, 16'hFFFF, 5'd16);
    for (int i = 0; i < 16; i++) begin
      it = make_item(ACT_LOAD, 0);
      it.point_index = i;
      it.point_time = (i == 15) ? 10'h3FF : i * 66;
      it.point_level = (i == 0) ? 10'd0 : (i == 7) ? 10'h3FF : $urandom_range(0, 1023);
      send(it);
    end
    send(make_item(ACT_SEEK, 32'd5));          // seek while idle is dropped
    send(make_item(ACT_START, 0));
    send(make_item(ACT_TICK, 32'd0));
    send(make_item(ACT_TICK, 32'd500));
    send(make_item(ACT_PAUSE, 0));
    send(make_item(ACT_PAUSE, 0));
    send(make_item(ACT_SLIP, 32'd7));          // slip while paused is dropped
    send(make_item(ACT_RESUME, 0));
    send(make_item(ACT_RESUME, 0));
    send(make_item(ACT_SEEK, 32'hFFFF_FFFF));  // clamps to the duration
    send(make_item(ACT_SLIP, 32'hFFFF_FFFF));
    send(make_item(ACT_TICK, 32'hFFFF_FFFF));  // clock wraps
    send(make_item(ACT_STOP, 0));
    drain();

    // Random phases, cycling through extreme and random settings.
    for (int p = 0; p < 19; p++) begin
      case (p % 5)
        0: dur = 32'd0;
        1: dur = 32'hFFFF_FFFF;
        2: dur = 32'd1;
        default: dur = (p > 10) ? $urandom() : $urandom_range(50, 5000);
      endcase
      if (p % 6 == 0) dur = $urandom_range(200, 3000);
      case (p % 3)
        0: fs = 16'hFFFF;
        1: fs = 16'd0;
        default: fs = $urandom();
      endcase
      case (p % 7)
        0: cnt = 5'd16;
        1: cnt = 5'd31;
        2: cnt = 5'd0;
        3: cnt = 5'd1;
        4: cnt = 5'd2;
        default: cnt = $urandom_range(0, 31);
      endcase
      quiet = (p % 4 == 3);
      set_config(dur, fs, cnt);
      send(make_item(ACT_START, 0));
      for (int i = 0; i < 99; i++) send(random_item(dur));
      drain();
      phases++;
    end

    quiet = 0;
    drain();
    repeat (300) @(posedge clk);
    $display("checked %0d results over %0d random phases, %0d while running",
             board.checked, phases, board.running_seen);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("mismatches: %0d, results still owed: %0d", board.errors, board.owed.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* timed_profile_setpoint_generator_unit.f */
hdl/tpsg_pkg.sv
hdl/tpsg_ram.sv
hdl/tpsg_div.sv
hdl/tpsg_ctrl.sv
hdl/tpsg_dp.sv
hdl/timed_profile_setpoint_generator_unit.sv
tb/sv/timed_profile_setpoint_generator_unit_tb.sv
